### rtl/rstab_pkg.sv
package rstab_pkg;

	localparam int unsigned SLOTS_DEFAULT     = 16;
	localparam int unsigned DATA_BITS_DEFAULT = 32;
	localparam int unsigned IDX_MAX_W         = 8;
	localparam int unsigned ID_W              = 16;
	localparam int unsigned PAYLOAD_W         = 32;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_MODIFY = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_MISSING = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]           op;
		logic [ID_W-1:0]      key_id;
		logic [PAYLOAD_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [3:0]           slot;
		logic [ID_W-1:0]      rec_id;
		logic [PAYLOAD_W-1:0] data_out;
	} rsp_t;

	typedef struct packed {
		logic                 go;
		logic [2:0]           op;
		logic [ID_W-1:0]      key_id;
		logic [PAYLOAD_W-1:0] data;
		logic [ID_W-1:0]      new_ident;
	} cmd_t;

	typedef struct packed {
		logic                 claimed;
		logic [IDX_MAX_W-1:0] idx;
		logic [ID_W-1:0]      rec_id;
		logic [PAYLOAD_W-1:0] data;
	} link_t;

endpackage

### rtl/rstab_cell.sv
module rstab_cell #(
	parameter int unsigned IDX     = 0,
	parameter int unsigned STORE_W = rstab_pkg::PAYLOAD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rstab_pkg::cmd_t  cmd,
	input  rstab_pkg::link_t link_in,
	output rstab_pkg::link_t link_out
);

	logic                       valid_q;
	logic [rstab_pkg::ID_W-1:0] ident_q;
	logic [STORE_W-1:0]         data_q;

	logic is_insert;
	logic is_search;
	logic hit;
	logic win;

	always_comb begin
		is_insert = (cmd.op == rstab_pkg::OP_INSERT);
		is_search = (cmd.op == rstab_pkg::OP_DELETE) || (cmd.op == rstab_pkg::OP_MODIFY) ||
			(cmd.op == rstab_pkg::OP_LOOKUP);
		hit = (is_insert && !valid_q) ||
			(is_search && valid_q && (ident_q == cmd.key_id));
		win = hit && !link_in.claimed;

		link_out         = link_in;
		link_out.claimed = link_in.claimed | hit;
		if (win) begin
			link_out.idx    = rstab_pkg::IDX_MAX_W'(IDX);
			link_out.rec_id = is_insert ? cmd.new_ident : ident_q;
			if (cmd.op == rstab_pkg::OP_LOOKUP) begin
				link_out.data = rstab_pkg::PAYLOAD_W'(data_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.go) begin
			if (cmd.op == rstab_pkg::OP_CLEAR) begin
				valid_q <= 1'b0;
			end else if (win && is_insert) begin
				valid_q <= 1'b1;
			end else if (win && (cmd.op == rstab_pkg::OP_DELETE)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go && win) begin
			if (is_insert) begin
				ident_q <= cmd.new_ident;
				data_q  <= cmd.data[STORE_W-1:0];
			end else if (cmd.op == rstab_pkg::OP_MODIFY) begin
				data_q <= cmd.data[STORE_W-1:0];
			end
		end
	end

endmodule

### rtl/record_slot_table.sv
// Flow: an accepted request is registered in req_q as the state goes to ST_EVAL;
// in ST_EVAL the result is registered in rsp_q and rsp_valid is raised.
// A new request is taken only in ST_IDLE, once no response is pending or it is
// being taken; the slot search ripples through the row of slot cells in ST_EVAL.
// Reset: arst_n clears all slot valid marks, the identifier counter and the
// handshake state at once; slot contents are kept unreset.
module record_slot_table #(
	parameter int unsigned SLOTS     = rstab_pkg::SLOTS_DEFAULT,
	parameter int unsigned DATA_BITS = rstab_pkg::DATA_BITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rstab_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rstab_pkg::rsp_t rsp
);

	localparam int unsigned STORE_W =
		(DATA_BITS < rstab_pkg::PAYLOAD_W) ? DATA_BITS : rstab_pkg::PAYLOAD_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t                     state_q;
	rstab_pkg::req_t            req_q;
	logic [rstab_pkg::ID_W-1:0] next_q;
	rstab_pkg::rsp_t            rsp_q;
	logic                       rsp_valid_q;

	rstab_pkg::cmd_t            cmd;
	rstab_pkg::link_t           links [SLOTS+1];
	rstab_pkg::link_t           tail;
	rstab_pkg::rsp_t            result;

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		cmd.go        = (state_q == ST_EVAL);
		cmd.op        = req_q.op;
		cmd.key_id    = req_q.key_id;
		cmd.data      = req_q.data_in;
		cmd.new_ident = next_q + rstab_pkg::ID_W'(1);
	end

	assign links[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		rstab_cell #(
			.IDX     (i),
			.STORE_W (STORE_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	assign tail = links[SLOTS];

	always_comb begin
		result = '0;
		case (req_q.op)
			rstab_pkg::OP_INSERT,
			rstab_pkg::OP_DELETE,
			rstab_pkg::OP_MODIFY,
			rstab_pkg::OP_LOOKUP: begin
				if (tail.claimed) begin
					result.status   = rstab_pkg::STATUS_OK;
					result.slot     = 4'(tail.idx);
					result.rec_id   = tail.rec_id;
					result.data_out = tail.data;
				end else if (req_q.op == rstab_pkg::OP_INSERT) begin
					result.status = rstab_pkg::STATUS_FULL;
				end else begin
					result.status = rstab_pkg::STATUS_MISSING;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (req_valid && req_ready) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q     <= ST_IDLE;
					rsp_valid_q <= 1'b1;
					if ((req_q.op == rstab_pkg::OP_INSERT) && tail.claimed) begin
						next_q <= cmd.new_ident;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == ST_EVAL) begin
			rsp_q <= result;
		end
	end

endmodule

### verif/record_slot_table_tb.sv
`timescale 1ns / 1ps

module record_slot_table_tb;

	localparam int unsigned TABLE_SLOTS  = rstab_pkg::SLOTS_DEFAULT;
	localparam int unsigned LIMIT_CYCLES = 3_000_000;
	localparam int unsigned RANDOM_REQS  = 1400;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam logic [2:0]  OP_NOOP_LO   = 3'd5;
	localparam logic [2:0]  OP_NOOP_HI   = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	rstab_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rstab_pkg::rsp_t rsp;

	logic                            tbl_valid [TABLE_SLOTS];
	logic [rstab_pkg::ID_W-1:0]      tbl_ident [TABLE_SLOTS];
	logic [rstab_pkg::PAYLOAD_W-1:0] tbl_data  [TABLE_SLOTS];
	logic [rstab_pkg::ID_W-1:0]      ident_ctr;

	rstab_pkg::rsp_t expected_rsp_q [$];
	rstab_pkg::rsp_t head_rsp;
	int unsigned     mismatch_count = 0;
	int unsigned     cycle_count = 0;
	int unsigned     rx_hold_cycles = 0;
	logic            idle_on;

	record_slot_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count == LIMIT_CYCLES);
		$display("record_slot_table_tb NOT OK");
		$finish;
	end

	function automatic rstab_pkg::rsp_t apply_table_op(rstab_pkg::req_t r);
		rstab_pkg::rsp_t res;
		int              hit;
		res = '0;
		hit = -1;
		case (r.op)
		rstab_pkg::OP_INSERT: begin
			for (int i = 0; i < TABLE_SLOTS; i++)
				if (!tbl_valid[i] && hit < 0) hit = i;
			if (hit < 0) begin
				res.status = rstab_pkg::STATUS_FULL;
			end else begin
				ident_ctr      = ident_ctr + 1'b1;
				tbl_valid[hit] = 1'b1;
				tbl_ident[hit] = ident_ctr;
				tbl_data[hit]  = r.data_in;
				res.slot       = hit[3:0];
				res.rec_id     = ident_ctr;
			end
		end
		rstab_pkg::OP_DELETE, rstab_pkg::OP_MODIFY, rstab_pkg::OP_LOOKUP: begin
			for (int i = 0; i < TABLE_SLOTS; i++)
				if (tbl_valid[i] && tbl_ident[i] == r.key_id && hit < 0) hit = i;
			if (hit < 0) begin
				res.status = rstab_pkg::STATUS_MISSING;
			end else begin
				res.slot   = hit[3:0];
				res.rec_id = tbl_ident[hit];
				if (r.op == rstab_pkg::OP_DELETE) tbl_valid[hit] = 1'b0;
				else if (r.op == rstab_pkg::OP_MODIFY) tbl_data[hit] = r.data_in;
				else res.data_out = tbl_data[hit];
			end
		end
		rstab_pkg::OP_CLEAR: begin
			for (int i = 0; i < TABLE_SLOTS; i++) tbl_valid[i] = 1'b0;
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	task automatic send_req(input logic [2:0] op, input logic [rstab_pkg::ID_W-1:0] key,
			input logic [rstab_pkg::PAYLOAD_W-1:0] data);
		int unsigned     gap;
		rstab_pkg::req_t r;
		gap       = idle_on ? $urandom_range(0, 4) : 0;
		r.op      = op;
		r.key_id  = key;
		r.data_in = data;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		expected_rsp_q.push_back(apply_table_op(r));
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val,
			act_val);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				note_mismatch("unexpected response", '0, 32'(rsp.status));
			end else begin
				head_rsp = expected_rsp_q.pop_front();
				if (rsp.status !== head_rsp.status)
					note_mismatch("status", 32'(head_rsp.status), 32'(rsp.status));
				if (rsp.slot !== head_rsp.slot)
					note_mismatch("slot", 32'(head_rsp.slot), 32'(rsp.slot));
				if (rsp.rec_id !== head_rsp.rec_id)
					note_mismatch("rec_id", 32'(head_rsp.rec_id), 32'(rsp.rec_id));
				if (rsp.data_out !== head_rsp.data_out)
					note_mismatch("data_out", head_rsp.data_out, rsp.data_out);
			end
		end
	end

	initial begin
		int unsigned stall;
		rsp_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles != 0) begin
				rsp_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			stall = idle_on ? $urandom_range(0, 4) : 0;
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid && rx_hold_cycles == 0);
		end
	end

	function automatic logic [rstab_pkg::ID_W-1:0] pick_key();
		int live [$];
		for (int i = 0; i < TABLE_SLOTS; i++)
			if (tbl_valid[i]) live.push_back(i);
		if (live.size() == 0 || $urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 16'hFFFF));
		return tbl_ident[live[$urandom_range(0, live.size() - 1)]];
	endfunction

	function automatic logic [2:0] pick_op();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) return rstab_pkg::OP_INSERT;
		if (roll < 55) return rstab_pkg::OP_DELETE;
		if (roll < 70) return rstab_pkg::OP_MODIFY;
		if (roll < 95) return rstab_pkg::OP_LOOKUP;
		if (roll < 97) return rstab_pkg::OP_CLEAR;
		return 3'($urandom_range(OP_NOOP_LO, OP_NOOP_HI));
	endfunction

	task automatic test_directed();
		send_req(rstab_pkg::OP_LOOKUP, '0, '0);
		send_req(rstab_pkg::OP_MODIFY, '1, '1);
		for (logic [3:0] op = 4'(OP_NOOP_LO); op <= 4'(OP_NOOP_HI); op++)
			send_req(op[2:0], 16'($urandom), $urandom);
		send_req(rstab_pkg::OP_INSERT, '0, '0);
		send_req(rstab_pkg::OP_INSERT, '1, '1);
		repeat (TABLE_SLOTS - 2) send_req(rstab_pkg::OP_INSERT, 16'($urandom), $urandom);
		send_req(rstab_pkg::OP_INSERT, '0, 32'h1234_5678);
		send_req(rstab_pkg::OP_MODIFY, 16'd1, 32'hA5A5_5A5A);
		send_req(rstab_pkg::OP_LOOKUP, 16'd1, '0);
		send_req(rstab_pkg::OP_LOOKUP, 16'd2, '0);
		send_req(rstab_pkg::OP_DELETE, 16'd5, '1);
		send_req(rstab_pkg::OP_INSERT, '0, 32'hCAFE_F00D);
		send_req(rstab_pkg::OP_LOOKUP, ident_ctr, '0);
		send_req(rstab_pkg::OP_CLEAR, '1, '1);
		send_req(rstab_pkg::OP_LOOKUP, ident_ctr, '0);
		send_req(rstab_pkg::OP_DELETE, 16'd2, '0);
	endtask

	task automatic test_random();
		for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
			if (n % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
			send_req(pick_op(), pick_key(), $urandom);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		idle_on        = 1'b0;
		rx_hold_cycles = HOLD_CYCLES;
		repeat (12) send_req(pick_op(), pick_key(), $urandom);
		idle_on = 1'b1;
		repeat (20) send_req(pick_op(), pick_key(), $urandom);
	endtask

	initial begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_ident[i] = '0;
			tbl_data[i]  = '0;
		end
		ident_ctr = '0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		idle_on   = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_backpressure();
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("record_slot_table_tb OK");
		end else begin
			$display("record_slot_table_tb NOT OK");
		end
		$finish;
	end

endmodule
